FILE: sv/epa_pkg.sv
`default_nettype none
package epa_pkg;

  localparam int CordicIterations = 16;
  localparam int AtanEntries      = 24;
  localparam int IterCount        = (CordicIterations > AtanEntries) ? AtanEntries
                                                                     : CordicIterations;
  localparam int IterW            = $clog2(AtanEntries);
  localparam logic [IterW-1:0] IterLast = IterW'(IterCount - 1);

  localparam int AngW   = 32;
  localparam int VecW   = 36;
  localparam int FracDrop = 16;
  localparam int DeltaW = VecW - FracDrop;
  localparam int SumW   = 24;

  localparam logic [15:0] GainInvQ16       = 16'd39797;
  localparam logic [15:0] FirstHarmonicRst = 16'hFFB5;  // -75
  localparam logic signed [SumW-1:0] SumMax = 24'sh7FFFFF;
  localparam logic signed [SumW-1:0] SumMin = 24'sh800000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ANGLE,
    ST_LOAD,
    ST_ITER,
    ST_ACC
  } epa_state_e;

  typedef struct packed {
    logic             load;
    logic             step;
    logic [IterW-1:0] iter;
  } epa_cordic_ctrl_t;

  typedef struct packed {
    logic capture;
    logic angle_en;
    logic acc_en;
  } epa_seq_t;

  // atan(2^-i) as 32-bit binary angles
  function automatic logic [AngW-1:0] atan_lookup(input logic [IterW-1:0] idx);
    logic [AngW-1:0] r;
    case (idx)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051E;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2F;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2FA;
      5'd15:   r = 32'h0000517D;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A30;
      5'd19:   r = 32'h00000518;
      5'd20:   r = 32'h0000028C;
      5'd21:   r = 32'h00000146;
      5'd22:   r = 32'h000000A3;
      5'd23:   r = 32'h00000051;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: sv/epa_cordic.sv
`default_nettype none
module epa_cordic (
  input  wire logic                             clk_i,
  input  wire epa_pkg::epa_cordic_ctrl_t        ctrl_i,
  input  wire logic [15:0]                      mag_i,
  input  wire logic [15:0]                      ang_i,
  output logic signed [epa_pkg::DeltaW-1:0]     dx_o,
  output logic signed [epa_pkg::DeltaW-1:0]     dy_o
);
  import epa_pkg::*;

  logic signed [VecW-1:0] x_q, x_d, y_q, y_d;
  logic signed [AngW:0]   z_q, z_d;

  logic [31:0]            prod;
  logic signed [VecW-1:0] x_init;
  logic                   fold;
  logic [AngW-1:0]        ang_full;
  logic signed [VecW-1:0] sh_x, sh_y;
  logic signed [AngW:0]   atan_v;
  logic [VecW-1:0]        rnd_x, rnd_y;

  always_comb begin
    prod     = 32'(mag_i * GainInvQ16);
    // outside [-1/4, 1/4) turn: negate the start vector and move by half a turn
    fold     = ang_i[15] ^ ang_i[14];
    ang_full = {ang_i, 16'h0000} + (fold ? 32'h80000000 : 32'h0);
    x_init   = signed'({{(VecW-32){1'b0}}, prod});
    sh_x     = x_q >>> ctrl_i.iter;
    sh_y     = y_q >>> ctrl_i.iter;
    atan_v   = signed'({1'b0, atan_lookup(ctrl_i.iter)});
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    if (ctrl_i.load) begin
      x_d = fold ? -x_init : x_init;
      y_d = '0;
      z_d = signed'({ang_full[AngW-1], ang_full});
    end else if (ctrl_i.step) begin
      if (!z_q[AngW]) begin
        x_d = x_q - sh_y;
        y_d = y_q + sh_x;
        z_d = z_q - atan_v;
      end else begin
        x_d = x_q + sh_y;
        y_d = y_q - sh_x;
        z_d = z_q + atan_v;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  // round off the 16 fraction bits to nearest, half up
  assign rnd_x = x_q + VecW'(32768);
  assign rnd_y = y_q + VecW'(32768);
  assign dx_o  = signed'(rnd_x[VecW-1:FracDrop]);
  assign dy_o  = signed'(rnd_y[VecW-1:FracDrop]);

endmodule
`default_nettype wire

FILE: sv/epa_ctrl.sv
`default_nettype none
module epa_ctrl (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  input  wire logic                      cfg_valid_i,
  input  wire logic                      out_pending_i,
  output logic                           in_ready_o,
  output logic                           cfg_ready_o,
  output epa_pkg::epa_seq_t              seq_o,
  output epa_pkg::epa_cordic_ctrl_t      cordic_o
);
  import epa_pkg::*;

  epa_state_e       state_q, state_d;
  logic [IterW-1:0] iter_q, iter_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i && !cfg_valid_i) state_d = ST_ANGLE;
      ST_ANGLE: state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_ITER;
      ST_ITER:  if (iter_q == IterLast) state_d = ST_ACC;
      ST_ACC:   if (!out_pending_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    iter_d = iter_q;
    if (state_q == ST_LOAD) iter_d = '0;
    else if (state_q == ST_ITER) iter_d = iter_q + 1'b1;
  end

  always_comb begin
    in_ready_o     = (state_q == ST_IDLE) && !cfg_valid_i;  // a config write takes priority
    cfg_ready_o    = (state_q == ST_IDLE);
    seq_o.capture  = (state_q == ST_IDLE) && in_valid_i && !cfg_valid_i;
    seq_o.angle_en = (state_q == ST_ANGLE);
    seq_o.acc_en   = (state_q == ST_ACC) && !out_pending_i;
    cordic_o.load  = (state_q == ST_LOAD);
    cordic_o.step  = (state_q == ST_ITER);
    cordic_o.iter  = iter_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
    end
  end

endmodule
`default_nettype wire

FILE: sv/epicycle_phasor_accumulator_top.sv
`default_nettype none
// Channel   Handshake                 Payload
// input     in_valid_i / in_ready_o   frame_time_i, magnitude_i, phase_i, last_term_i
// result    out_valid_o / out_ready_i point_x_o, point_y_o, frame_end_o
// config    cfg_valid_i / cfg_ready_o first_harmonic_i
//
// An item goes through angle multiply, vector load, 16 micro-rotations of the
// one shared CORDIC stage, then accumulate; the input is not ready again until
// the block is back in idle, so a new item is taken only after the last is through.
// The result register lets the next item be taken while a point waits; the
// accumulate step holds until that point has been taken.
// Reset clears the sums and loads the harmonic with -75; a config write does
// the same with the written value.
module epicycle_phasor_accumulator_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [15:0]        first_harmonic_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [15:0]        frame_time_i,
  input  wire logic [15:0]        magnitude_i,
  input  wire logic [15:0]        phase_i,
  input  wire logic               last_term_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [23:0]      point_x_o,
  output logic signed [23:0]      point_y_o,
  output logic                    frame_end_o
);
  import epa_pkg::*;

  epa_seq_t         seq;
  epa_cordic_ctrl_t cordic_ctrl;

  logic [15:0] fh_q, harmonic_q, t_q, mag_q, ph_q, ang_q;
  logic        last_q;
  logic signed [SumW-1:0]   sum_x_q, sum_y_q, sum_x_d, sum_y_d;
  logic signed [DeltaW-1:0] dx, dy;
  logic signed [SumW+1:0]   ext_x, ext_y;
  logic [31:0] nt;
  logic        out_valid_q, frame_end_q;
  logic signed [SumW-1:0] px_q, py_q;
  logic        cfg_wr;

  epa_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .cfg_valid_i   (cfg_valid_i),
    .out_pending_i (out_valid_q && !out_ready_i),
    .in_ready_o    (in_ready_o),
    .cfg_ready_o   (cfg_ready_o),
    .seq_o         (seq),
    .cordic_o      (cordic_ctrl)
  );

  epa_cordic u_cordic (
    .clk_i  (clk_i),
    .ctrl_i (cordic_ctrl),
    .mag_i  (mag_q),
    .ang_i  (ang_q),
    .dx_o   (dx),
    .dy_o   (dy)
  );

  assign cfg_wr = cfg_valid_i && cfg_ready_o;
  assign nt     = 32'(harmonic_q * t_q);

  function automatic logic signed [SumW-1:0] sat(input logic signed [SumW+1:0] v);
    logic signed [SumW-1:0] r;
    if (v > SumW'(SumMax)) r = SumMax;
    else if (v < SumW'(SumMin)) r = SumMin;
    else r = v[SumW-1:0];
    return r;
  endfunction

  always_comb begin
    ext_x   = (SumW+2)'(sum_x_q) + (SumW+2)'(dx);
    ext_y   = (SumW+2)'(sum_y_q) + (SumW+2)'(dy);
    sum_x_d = sat(ext_x);
    sum_y_d = sat(ext_y);
  end

  always_ff @(posedge clk_i) begin
    if (seq.capture) begin
      t_q    <= frame_time_i;
      mag_q  <= magnitude_i;
      ph_q   <= phase_i;
      last_q <= last_term_i;
    end
    if (seq.angle_en) ang_q <= ph_q + nt[15:0];
    if (seq.acc_en) begin
      px_q        <= sum_x_d;
      py_q        <= sum_y_d;
      frame_end_q <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fh_q        <= FirstHarmonicRst;
      harmonic_q  <= FirstHarmonicRst;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        fh_q       <= first_harmonic_i;
        harmonic_q <= first_harmonic_i;
        sum_x_q    <= '0;
        sum_y_q    <= '0;
      end else if (seq.acc_en) begin
        if (last_q) begin
          harmonic_q <= fh_q;
          sum_x_q    <= '0;
          sum_y_q    <= '0;
        end else begin
          harmonic_q <= harmonic_q + 16'd1;
          sum_x_q    <= sum_x_d;
          sum_y_q    <= sum_y_d;
        end
      end
      if (seq.acc_en) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign point_x_o   = px_q;
  assign point_y_o   = py_q;
  assign frame_end_o = frame_end_q;

endmodule
`default_nettype wire

FILE: sv/epa_checker.sv
`default_nettype none
module epa_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              cfg_valid_i,
  input wire logic              cfg_ready_o,
  input wire logic [15:0]       first_harmonic_i,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic [15:0]       frame_time_i,
  input wire logic [15:0]       magnitude_i,
  input wire logic [15:0]       phase_i,
  input wire logic              last_term_i,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic signed [23:0] point_x_o,
  input wire logic signed [23:0] point_y_o,
  input wire logic              frame_end_o
);

  // once an item is in, input ready drops and does not come straight back
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o)
    else $error("input ready too soon after an item");

  // a new point only appears at the end of an item's work
  a_point_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o) && $past(!cfg_ready_o))
    else $error("point raised while idle");

  // config and input share the idle window
  a_cfg_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> cfg_ready_o)
    else $error("item taken while config blocked");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(point_x_o)
      && $stable(point_y_o) && $stable(frame_end_o))
    else $error("pending point changed");

endmodule

bind epicycle_phasor_accumulator_top epa_checker u_epa_checker (.*);
`default_nettype wire

FILE: verif/epa_point_checker.sv
`default_nettype none
module epa_point_checker (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  input  wire logic              cfg_ready_i,
  input  wire logic [15:0]       first_harmonic_i,
  input  wire logic              in_valid_i,
  input  wire logic              in_ready_i,
  input  wire logic [15:0]       frame_time_i,
  input  wire logic [15:0]       magnitude_i,
  input  wire logic [15:0]       phase_i,
  input  wire logic              last_term_i,
  input  wire logic              out_valid_i,
  input  wire logic              out_ready_i,
  input  wire logic signed [23:0] point_x_i,
  input  wire logic signed [23:0] point_y_i,
  input  wire logic              frame_end_i,
  output int                     pending_o,
  output int                     errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Rotations = (epa_pkg::CordicIterations > 24) ? 24 : epa_pkg::CordicIterations;
  localparam longint GainInv = 39797;  // 1/K in Q0.16
  localparam longint SumTop = 8388607;
  localparam longint SumBottom = -8388608;
  localparam logic [15:0] HarmonicAtReset = 16'hFFB5;  // -75

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic               frame_end;
  } point_t;

  // atan(2^-i), 2^32 units per turn
  logic [31:0] atan_turn [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  logic [15:0]        start_harmonic = HarmonicAtReset;
  logic [15:0]        harmonic = HarmonicAtReset;
  logic signed [23:0] acc_x = '0;
  logic signed [23:0] acc_y = '0;
  point_t             point_q[$];
  point_t             head;
  int                 points_seen = 0;
  int                 error_count = 0;
  int                 pending_q = 0;

  assign pending_o = pending_q;
  assign errors_o  = error_count;

  task automatic report_error(input string msg);
    $display("%s", msg);
    error_count++;
  endtask

  function automatic logic signed [23:0] sat_accumulate(input logic signed [23:0] acc,
                                                        input longint d);
    longint r;
    r = longint'(acc) + d;
    if (r > SumTop) return 24'sh7FFFFF;
    if (r < SumBottom) return 24'sh800000;
    return 24'(r);
  endfunction

  // Rotates one coefficient by phase + n*t, adds it to the running sum and
  // steps the harmonic (or restarts the frame on the last term).
  function automatic point_t advance_sum(input logic [15:0] t, input logic [15:0] mag,
                                         input logic [15:0] ph, input logic lst);
    logic [15:0] ang16;
    logic [31:0] ang;
    longint      x;
    longint      y;
    longint      z;
    longint      dx;
    longint      dy;
    point_t      pt;
    ang16 = ph + harmonic * t;
    ang = {ang16, 16'h0000};
    x = longint'({48'd0, mag}) * GainInv;
    y = 0;
    // fold the outer half turn into [-1/4, 1/4)
    if (ang[31:30] == 2'b01 || ang[31:30] == 2'b10) begin
      x = -x;
      ang = ang + 32'h8000_0000;
    end
    z = longint'(signed'(ang));
    for (int i = 0; i < Rotations; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= longint'({32'd0, atan_turn[i]});
      end else begin
        x += dx;
        y -= dy;
        z += longint'({32'd0, atan_turn[i]});
      end
    end
    acc_x = sat_accumulate(acc_x, (x + 32768) >>> 16);
    acc_y = sat_accumulate(acc_y, (y + 32768) >>> 16);
    pt.x = acc_x;
    pt.y = acc_y;
    pt.frame_end = lst;
    if (lst) begin
      acc_x = '0;
      acc_y = '0;
      harmonic = start_harmonic;
    end else begin
      harmonic = harmonic + 16'd1;
    end
    return pt;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_harmonic = HarmonicAtReset;
      harmonic = HarmonicAtReset;
      acc_x = '0;
      acc_y = '0;
      point_q.delete();
      pending_q <= 0;
    end else begin
      // results first: an item taken at this edge cannot have produced one yet
      if (out_valid_i && out_ready_i) begin
        if (point_q.size() == 0) begin
          report_error($sformatf("ERROR point %0d unexpected: x=%0d y=%0d end=%0b",
                                 points_seen, point_x_i, point_y_i, frame_end_i));
        end else begin
          head = point_q.pop_front();
          if (point_x_i !== head.x)
            report_error($sformatf("ERROR point %0d point_x: got %0d, expected %0d",
                                   points_seen, point_x_i, head.x));
          if (point_y_i !== head.y)
            report_error($sformatf("ERROR point %0d point_y: got %0d, expected %0d",
                                   points_seen, point_y_i, head.y));
          if (frame_end_i !== head.frame_end)
            report_error($sformatf("ERROR point %0d frame_end: got %0b, expected %0b",
                                   points_seen, frame_end_i, head.frame_end));
        end
        points_seen++;
      end
      if (cfg_valid_i && cfg_ready_i) begin
        start_harmonic = first_harmonic_i;
        harmonic = first_harmonic_i;
        acc_x = '0;
        acc_y = '0;
      end
      if (in_valid_i && in_ready_i)
        point_q.push_back(advance_sum(frame_time_i, magnitude_i, phase_i, last_term_i));
      pending_q <= point_q.size();
    end
  end

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Phases = 8;
  localparam int ItemsPerPhase = 165;
  localparam int StallLimit = 2000;
  localparam int Settle = 40;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic [15:0]        cfg_harmonic = '0;
  logic               in_valid = 1'b0;
  logic [15:0]        frame_time = '0;
  logic [15:0]        magnitude = '0;
  logic [15:0]        phase = '0;
  logic               last_term = 1'b0;
  logic               out_ready = 1'b0;
  logic               cfg_ready;
  logic               in_ready;
  logic               out_valid;
  logic signed [23:0] point_x;
  logic signed [23:0] point_y;
  logic               frame_end;
  int                 pending;
  int                 errors;
  int                 src_gap_pct = 0;
  int                 sink_stall_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  epicycle_phasor_accumulator_top DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .first_harmonic_i (cfg_harmonic),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .frame_time_i     (frame_time),
    .magnitude_i      (magnitude),
    .phase_i          (phase),
    .last_term_i      (last_term),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .point_x_o        (point_x),
    .point_y_o        (point_y),
    .frame_end_o      (frame_end)
  );

  epa_point_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .first_harmonic_i (cfg_harmonic),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .frame_time_i     (frame_time),
    .magnitude_i      (magnitude),
    .phase_i          (phase),
    .last_term_i      (last_term),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .point_x_i        (point_x),
    .point_y_i        (point_y),
    .frame_end_i      (frame_end),
    .pending_o        (pending),
    .errors_o         (errors)
  );

  // result side back-pressure
  initial begin : sink
    int burst;
    forever begin
      @(posedge clk);
      if (rst_n && $urandom_range(0, 99) < sink_stall_pct) begin
        burst = $urandom_range(1, 9);
        out_ready <= 1'b0;
        repeat (burst) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  task automatic drive_coef(input logic [15:0] t, input logic [15:0] mag,
                            input logic [15:0] ph, input logic lst);
    int gap;
    if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    frame_time <= t;
    magnitude  <= mag;
    phase      <= ph;
    last_term  <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // hold the source until every point in flight has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int          frame_left;
    int          sat_dir;
    logic        sat_pending;
    logic        sat_frame;
    logic [15:0] fh;
    logic [15:0] t;
    logic [15:0] mag;
    logic [15:0] ph;
    logic [15:0] sat_base;
    frame_left = 0;
    sat_dir = 0;
    sat_pending = 1'b0;
    sat_frame = 1'b0;
    sat_base = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: quadrant fold boundaries, field extremes, a one-term frame
    drive_coef(16'h0000, 16'h0000, 16'h0000, 1'b0);
    drive_coef(16'h0000, 16'hFFFF, 16'h0000, 1'b0);
    drive_coef(16'h0000, 16'hFFFF, 16'h3FFF, 1'b0);
    drive_coef(16'h0000, 16'hFFFF, 16'h4000, 1'b0);
    drive_coef(16'h0000, 16'hFFFF, 16'h7FFF, 1'b0);
    drive_coef(16'h0000, 16'hFFFF, 16'h8000, 1'b0);
    drive_coef(16'h0000, 16'hFFFF, 16'hBFFF, 1'b0);
    drive_coef(16'h0000, 16'hFFFF, 16'hC000, 1'b0);
    drive_coef(16'h0000, 16'hFFFF, 16'hFFFF, 1'b0);
    drive_coef(16'hFFFF, 16'h0100, 16'h0000, 1'b1);
    drive_coef(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    drive_coef(16'h8000, 16'h8000, 16'h8000, 1'b1);
    drive_coef(16'h0001, 16'h0001, 16'h0000, 1'b1);
    drive_coef(16'h5555, 16'hAAAA, 16'h5555, 1'b0);
    drive_coef(16'hAAAA, 16'h5555, 16'hAAAA, 1'b1);

    for (int p = 0; p < Phases; p++) begin
      case (p)
        0: fh = 16'h7FFF;
        1: fh = 16'h8000;
        2: fh = 16'hFFFF;
        3: fh = 16'h0000;
        4: fh = 16'h0001;
        Phases - 1: fh = 16'hFFB5;
        default: fh = 16'($urandom_range(0, 65535));
      endcase
      wait_drained();
      cfg_valid    <= 1'b1;
      cfg_harmonic <= fh;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      cfg_valid <= 1'b0;

      if (p == Phases - 1) begin
        src_gap_pct = 0;
        sink_stall_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: src_gap_pct = 0;
          1: src_gap_pct = 15;
          default: src_gap_pct = 50;
        endcase
        case ($urandom_range(0, 2))
          0: sink_stall_pct = 0;
          1: sink_stall_pct = 15;
          default: sink_stall_pct = 50;
        endcase
      end

      // the write restarted the frame; two phases open with a saturating run
      frame_left = 0;
      sat_pending = (p == 1 || p == 5);
      for (int k = 0; k < ItemsPerPhase; k++) begin
        if (frame_left == 0) begin
          sat_frame = sat_pending || ($urandom_range(0, 39) == 0);
          if (sat_frame) begin
            if (p == 1) sat_dir = 0;
            else if (p == 5) sat_dir = 2;
            else sat_dir = $urandom_range(0, 3);
            sat_base = 16'(sat_dir * 16384);
            frame_left = $urandom_range(145, 160);
          end else begin
            frame_left = $urandom_range(1, 12);
          end
          sat_pending = 1'b0;
        end
        if (sat_frame) begin
          // t = 0 keeps every term pointing the same way
          t = 16'h0000;
          mag = 16'($urandom_range(61000, 65535));
          ph = sat_base + 16'($urandom_range(0, 400)) - 16'd200;
        end else begin
          case ($urandom_range(0, 7))
            0: t = 16'h0000;
            1: t = 16'hFFFF;
            2: t = 16'h8000;
            default: t = 16'($urandom_range(0, 65535));
          endcase
          case ($urandom_range(0, 7))
            0: mag = 16'h0000;
            1: mag = 16'hFFFF;
            2, 3: mag = 16'($urandom_range(0, 255));
            default: mag = 16'($urandom_range(0, 65535));
          endcase
          if ($urandom_range(0, 7) == 0)
            ph = 16'($urandom_range(0, 3) * 16384) - 16'($urandom_range(0, 1));
          else
            ph = 16'($urandom_range(0, 65535));
        end
        drive_coef(t, mag, ph, frame_left == 1);
        frame_left--;
        if ((p == 3 && k == 20) || $urandom_range(0, 199) == 0)
          wait_drained();
      end
    end

    wait_drained();
    repeat (Settle) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
`default_nettype wire

FILE: sim.f
sv/epa_pkg.sv
sv/epa_cordic.sv
sv/epa_ctrl.sv
sv/epicycle_phasor_accumulator_top.sv
sv/epa_checker.sv
verif/epa_point_checker.sv
verif/tb_top.sv
